/* src/thw_pkg.sv */
// Shared types and constants for the task heartbeat watchdog.
// No dependencies; used by the top level and by its port checker.
`default_nettype none

package thw_pkg;

    localparam int TASKS      = 5;
    localparam int TASK_BITS  = 3;
    localparam int BEAT_BITS  = 32;
    localparam int COUNT_BITS = 8;
    localparam int LIMIT_BITS = 8;
    localparam int MASK_BITS  = 5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [LIMIT_BITS-1:0] LIMIT_AT_RESET = 8'd3;
    localparam logic [MASK_BITS-1:0]  MASK_AT_RESET  = 5'd15;

    // Slave tdata: task_index, heartbeat_value, zero fill to 40 bits.
    localparam int S_DATA_BITS = 40;
    // Master tdata: result_task, missed_checks, four flags, zero fill to 16 bits.
    localparam int M_DATA_BITS = 16;
    localparam int M_TASK_LSB    = 0;
    localparam int M_COUNT_LSB   = 3;
    localparam int M_STALL_BIT   = 11;
    localparam int M_RAISED_BIT  = 12;
    localparam int M_ACTIVE_BIT  = 13;
    localparam int M_REFRESH_BIT = 14;

    localparam int ADDR_BITS = 3;

    typedef enum logic [0:0] {
        REG_MISSED_LIMIT  = 1'b0,
        REG_CRITICAL_MASK = 1'b1
    } cfg_reg_t;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [BEAT_BITS-1:0]  beat_t;

endpackage

`default_nettype wire

/* src/task_heartbeat_watchdog.sv */
// Task heartbeat watchdog: top level, one register stage in, one out.
// Depends on thw_pkg for widths, reset values and tdata layout.
`default_nettype none

//  port group | dir | request content
//  -----------+-----+-------------------------------------------------------
//  s_axis     | in  | task_index, heartbeat_value in tdata; last_of_round tlast
//  m_axis     | out | result_task, missed_checks, stall/fault/refresh flags
//  apb        | in  | missed_limit at 0x0, critical_mask at 0x4
//
//  Each request passes through the single compare/increment stage;
//  a new request is accepted every cycle when the result side keeps up.
//  m_tvalid rises once the result register loads: the input register loads at the
//  accepting edge, the result register when the request advances out of it.
//  The state table update and the result register load share one edge, so
//  back-to-back requests for the same task see the updated count.
//  Reset (aresetn low, synchronous) clears counters, the snapshot flag,
//  the fault latch and both valid flags; heartbeat snapshots are not reset.
//  A stall on m_tready holds the result; the input register fills, then
//  s_tready drops until the result drains.

module task_heartbeat_watchdog (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // slave tdata, low bit up: task_index[2:0], heartbeat_value[34:3], zero[39:35]
    input  wire logic [thw_pkg::S_DATA_BITS-1:0]    s_tdata,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tlast,
    output      logic                               s_tready,
    // master tdata, low bit up: result_task[2:0], missed_checks[10:3],
    // stall_reported[11], fault_raised[12], fault_active[13],
    // refresh_pulse[14], zero[15]
    output      logic [thw_pkg::M_DATA_BITS-1:0]    m_tdata,
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [thw_pkg::ADDR_BITS-1:0]      paddr,
    input  wire logic [31:0]                        pwdata,
    output      logic [31:0]                        prdata,
    output      logic                               pready
);

    // configuration registers
    logic [thw_pkg::LIMIT_BITS-1:0] missed_limit_reg;
    logic [thw_pkg::MASK_BITS-1:0]  critical_mask_reg;
    thw_pkg::cfg_reg_t              cfg_sel;
    logic                           cfg_write;

    // input register
    logic                           in_valid_reg;
    logic [thw_pkg::TASK_BITS-1:0]  in_task_reg;
    thw_pkg::beat_t                 in_beat_reg;
    logic                           in_last_reg;

    // supervisor state
    thw_pkg::beat_t                 last_heartbeat_reg [thw_pkg::TASKS];
    thw_pkg::count_t                missed_counter_reg [thw_pkg::TASKS];
    logic                           snapshot_taken_reg;
    logic                           fault_latch_reg;

    // result register
    logic                           out_valid_reg;
    logic [thw_pkg::M_DATA_BITS-1:0] out_data_reg;

    // compute stage
    logic                           advance;
    logic                           task_ok;
    logic                           same_beat;
    thw_pkg::count_t                count_old;
    thw_pkg::count_t                count_inc;
    thw_pkg::count_t                count_next;
    logic                           stall;
    logic                           critical;
    logic                           raised;
    logic                           fault_next;
    logic                           refresh;
    thw_pkg::count_t                count_out;
    logic [thw_pkg::M_DATA_BITS-1:0] out_data_next;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_sel   = thw_pkg::cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (cfg_sel)
            thw_pkg::REG_MISSED_LIMIT: begin
                prdata[thw_pkg::LIMIT_BITS-1:0] = missed_limit_reg;
            end
            thw_pkg::REG_CRITICAL_MASK: begin
                prdata[thw_pkg::MASK_BITS-1:0] = critical_mask_reg;
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            missed_limit_reg  <= thw_pkg::LIMIT_AT_RESET;
            critical_mask_reg <= thw_pkg::MASK_AT_RESET;
        end else if (cfg_write) begin
            case (cfg_sel)
                thw_pkg::REG_MISSED_LIMIT: begin
                    missed_limit_reg <= pwdata[thw_pkg::LIMIT_BITS-1:0];
                end
                thw_pkg::REG_CRITICAL_MASK: begin
                    critical_mask_reg <= pwdata[thw_pkg::MASK_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- handshake ----------------
    // Advance the input register into the result register whenever the
    // result slot is empty or being taken this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_task_reg <= s_tdata[thw_pkg::TASK_BITS-1:0];
            in_beat_reg <= s_tdata[thw_pkg::TASK_BITS +: thw_pkg::BEAT_BITS];
            in_last_reg <= s_tlast;
        end
    end

    // ---------------- compare and count ----------------
    always_comb begin
        task_ok   = 32'(in_task_reg) < thw_pkg::TASKS;
        same_beat = task_ok && (in_beat_reg == last_heartbeat_reg[in_task_reg]);
        count_old = task_ok ? missed_counter_reg[in_task_reg] : '0;
        count_inc = (count_old == thw_pkg::COUNT_MAX) ? count_old : count_old + 1'b1;

        // Hold during the snapshot round; same beat increments, new beat clears.
        if (!snapshot_taken_reg) begin
            count_next = count_old;
        end else if (same_beat) begin
            count_next = count_inc;
        end else begin
            count_next = '0;
        end

        critical = task_ok && (32'(in_task_reg) < thw_pkg::MASK_BITS)
                   && critical_mask_reg[in_task_reg];
        stall    = snapshot_taken_reg && same_beat
                   && (thw_pkg::LIMIT_BITS'(count_next) == missed_limit_reg);
        raised   = snapshot_taken_reg && same_beat && critical
                   && (thw_pkg::LIMIT_BITS'(count_next) >= missed_limit_reg)
                   && !fault_latch_reg;
        fault_next = fault_latch_reg || raised;
        refresh    = in_last_reg && snapshot_taken_reg && !fault_next;
        count_out  = task_ok ? count_next : '0;

        out_data_next = '0;
        out_data_next[thw_pkg::M_TASK_LSB +: thw_pkg::TASK_BITS] = in_task_reg;
        out_data_next[thw_pkg::M_COUNT_LSB +: thw_pkg::COUNT_BITS] = count_out;
        out_data_next[thw_pkg::M_STALL_BIT]   = stall;
        out_data_next[thw_pkg::M_RAISED_BIT]  = raised;
        out_data_next[thw_pkg::M_ACTIVE_BIT]  = fault_next;
        out_data_next[thw_pkg::M_REFRESH_BIT] = refresh;
    end

    // ---------------- state update ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < thw_pkg::TASKS; i++) begin
                missed_counter_reg[i] <= '0;
            end
            snapshot_taken_reg <= 1'b0;
            fault_latch_reg    <= 1'b0;
        end else if (advance) begin
            if (task_ok) begin
                missed_counter_reg[in_task_reg] <= count_next;
            end
            fault_latch_reg <= fault_next;
            if (in_last_reg) begin
                snapshot_taken_reg <= 1'b1;
            end
        end
    end

    // Snapshots carry no reset; an entry is valid once its task is seen.
    always_ff @(posedge aclk) begin
        if (advance && task_ok) begin
            last_heartbeat_reg[in_task_reg] <= in_beat_reg;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

/* src/thw_checker.sv */
// Port-level checker for the task heartbeat watchdog, bound to the top level.
// Depends on thw_pkg for the master tdata layout.
`default_nettype none

module thw_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic [thw_pkg::M_DATA_BITS-1:0] m_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready
);

    // A result that latches the fault must show the fault as active.
    a_raised_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[thw_pkg::M_RAISED_BIT] |-> m_tdata[thw_pkg::M_ACTIVE_BIT])
        else $error("fault_raised without fault_active");

    // Never kick the hardware watchdog while the fault is latched.
    a_refresh_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[thw_pkg::M_REFRESH_BIT] |-> !m_tdata[thw_pkg::M_ACTIVE_BIT])
        else $error("refresh_pulse with fault active");

    // A stall report needs a nonzero count (a zero limit never reports).
    a_stall_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[thw_pkg::M_STALL_BIT]
        |-> m_tdata[thw_pkg::M_COUNT_LSB +: thw_pkg::COUNT_BITS] != '0)
        else $error("stall_reported with zero missed count");

    // Reset drops any pending result.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind task_heartbeat_watchdog thw_checker u_thw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
